[hw/rtl/rwlm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlm_pkg
// Shared types and constants of the reader-writer lock manager: request and
// result transaction structs, request and event codes, and the control and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rwlm_pkg;

  localparam logic [1:0] KIND_ACQ_SHARED = 2'd0;
  localparam logic [1:0] KIND_ACQ_EXCL   = 2'd1;
  localparam logic [1:0] KIND_REL_SHARED = 2'd2;
  localparam logic [1:0] KIND_REL_EXCL   = 2'd3;

  localparam logic [1:0] EV_GRANTED  = 2'd0;
  localparam logic [1:0] EV_QUEUED   = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;
  localparam logic [1:0] EV_DROPPED  = 2'd3;

  localparam int HOLDERS_WIDTH = 10;
  localparam logic signed [HOLDERS_WIDTH-1:0] HOLDERS_MAX    = 10'sd511;
  localparam logic signed [HOLDERS_WIDTH-1:0] HOLDERS_WRITER = -10'sd1;
  localparam logic signed [HOLDERS_WIDTH-1:0] HOLDERS_ONE    = 10'sd1;
  localparam logic signed [HOLDERS_WIDTH-1:0] HOLDERS_FREE   = 10'sd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] requester_id;
  } in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] who;
    logic       exclusive_grant;
    logic       is_last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic eval;   // evaluate the request and emit its first result
    logic wake;   // grant the waiter at the head of the selected queue
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the output register can take a result this cycle
    logic wake_pend;   // the request being evaluated wakes at least one waiter
    logic wake_more;   // another reader follows the one being woken
  } sts_t;

endpackage

[hw/rtl/rwlm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlm_fifo
// Waiter queue: a circular buffer of requester ids with a head pointer and a
// fill count. The entry at the head is read into a register every cycle.
// ----------------------------------------------------------------------------
module rwlm_fifo #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             single,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [AW:0]      wr_sum;
  logic [AW:0]      wr_wrap;
  logic [AW-1:0]    wr_pos;

  // The tail sits fill entries past the head, wrapped once at most.
  assign wr_sum  = (AW + 1)'(head_r) + (AW + 1)'(fill_r);
  assign wr_wrap = (wr_sum >= (AW + 1)'(DEPTH)) ? (wr_sum - (AW + 1)'(DEPTH)) : wr_sum;
  assign wr_pos  = wr_wrap[AW-1:0];

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end else if (push) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_pos] <= wr_data;
    end
    rd_data_r <= mem[head_r];
  end

  assign rd_data = rd_data_r;
  assign empty   = (fill_r == '0);
  assign single  = (fill_r == FW'(1));
  assign full    = (fill_r == FW'(DEPTH));

endmodule

[hw/rtl/rwlm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlm_datapath
// Lock state, waiter queues and result register. Decides grant, queue, drop
// or release for a request and grants woken waiters on command.
// ----------------------------------------------------------------------------
module rwlm_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rwlm_pkg::in_t in_data,
  input  rwlm_pkg::cmd_t cmd,
  output rwlm_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output rwlm_pkg::out_t out_data
);

  rwlm_pkg::in_t   req_r;
  rwlm_pkg::out_t  out_r, out_nxt;
  logic            out_valid_r;
  logic            wake_rd_r, wake_rd_nxt;
  logic signed [rwlm_pkg::HOLDERS_WIDTH-1:0] holders_r, holders_nxt;

  logic [ID_WIDTH+7:0] req_ext;
  logic [ID_WIDTH-1:0] req_id;
  logic [ID_WIDTH+7:0] req_who_ext;
  logic [ID_WIDTH-1:0] head_id;
  logic [ID_WIDTH+7:0] head_who_ext;

  logic                rq_push, rq_pop, wq_push, wq_pop;
  logic [ID_WIDTH-1:0] rq_rd, wq_rd;
  logic                rq_empty, rq_single, rq_full;
  logic                wq_empty, wq_single, wq_full;
  logic                wake_pend;

  // The id is kept in its low ID_WIDTH bits; results show its low byte.
  assign req_ext      = {{ID_WIDTH{1'b0}}, req_r.requester_id};
  assign req_id       = req_ext[ID_WIDTH-1:0];
  assign req_who_ext  = {8'b0, req_id};
  assign head_id      = wake_rd_r ? rq_rd : wq_rd;
  assign head_who_ext = {8'b0, head_id};

  rwlm_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_WIDTH)) u_reader_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .pop     (rq_pop),
    .wr_data (req_id),
    .rd_data (rq_rd),
    .empty   (rq_empty),
    .single  (rq_single),
    .full    (rq_full)
  );

  rwlm_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_WIDTH)) u_writer_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (wq_push),
    .pop     (wq_pop),
    .wr_data (req_id),
    .rd_data (wq_rd),
    .empty   (wq_empty),
    .single  (wq_single),
    .full    (wq_full)
  );

  // A release wakes waiters only when it actually frees the lock.
  always_comb begin
    wake_pend   = 1'b0;
    wake_rd_nxt = wake_rd_r;
    unique case (req_r.kind)
      rwlm_pkg::KIND_REL_SHARED: begin
        wake_pend = (holders_r == rwlm_pkg::HOLDERS_ONE) && !wq_empty;
      end
      rwlm_pkg::KIND_REL_EXCL: begin
        wake_pend = (holders_r == rwlm_pkg::HOLDERS_WRITER) && (!rq_empty || !wq_empty);
      end
      default: begin
        wake_pend = 1'b0;
      end
    endcase
    // Only an exclusive release hands the lock to the queued readers; the last
    // shared release wakes only a writer, and only if one is queued.
    if (cmd.eval) begin
      wake_rd_nxt = (req_r.kind == rwlm_pkg::KIND_REL_EXCL) && !rq_empty;
    end
  end

  always_comb begin
    holders_nxt = holders_r;
    out_nxt     = out_r;
    rq_push     = 1'b0;
    rq_pop      = 1'b0;
    wq_push     = 1'b0;
    wq_pop      = 1'b0;
    if (cmd.eval) begin
      out_nxt.who     = req_who_ext[7:0];
      out_nxt.is_last = !wake_pend;
      unique case (req_r.kind)
        rwlm_pkg::KIND_ACQ_SHARED: begin
          out_nxt.exclusive_grant = 1'b0;
          if (!wq_empty || holders_r[rwlm_pkg::HOLDERS_WIDTH-1]) begin
            if (!rq_full) begin
              rq_push           = 1'b1;
              out_nxt.event_res = rwlm_pkg::EV_QUEUED;
            end else begin
              out_nxt.event_res = rwlm_pkg::EV_DROPPED;
            end
          end else if (holders_r == rwlm_pkg::HOLDERS_MAX) begin
            out_nxt.event_res = rwlm_pkg::EV_DROPPED;
          end else begin
            holders_nxt       = holders_r + rwlm_pkg::HOLDERS_ONE;
            out_nxt.event_res = rwlm_pkg::EV_GRANTED;
          end
        end
        rwlm_pkg::KIND_ACQ_EXCL: begin
          out_nxt.exclusive_grant = 1'b1;
          if (holders_r == rwlm_pkg::HOLDERS_FREE) begin
            holders_nxt       = rwlm_pkg::HOLDERS_WRITER;
            out_nxt.event_res = rwlm_pkg::EV_GRANTED;
          end else if (!wq_full) begin
            wq_push           = 1'b1;
            out_nxt.event_res = rwlm_pkg::EV_QUEUED;
          end else begin
            out_nxt.event_res = rwlm_pkg::EV_DROPPED;
          end
        end
        rwlm_pkg::KIND_REL_SHARED: begin
          out_nxt.exclusive_grant = 1'b0;
          out_nxt.event_res       = rwlm_pkg::EV_RELEASED;
          if (!holders_r[rwlm_pkg::HOLDERS_WIDTH-1] && holders_r != rwlm_pkg::HOLDERS_FREE) begin
            holders_nxt = holders_r - rwlm_pkg::HOLDERS_ONE;
          end
        end
        rwlm_pkg::KIND_REL_EXCL: begin
          out_nxt.exclusive_grant = 1'b1;
          out_nxt.event_res       = rwlm_pkg::EV_RELEASED;
          if (holders_r == rwlm_pkg::HOLDERS_WRITER) begin
            holders_nxt = rwlm_pkg::HOLDERS_FREE;
          end
        end
        default: begin
          out_nxt.exclusive_grant = 1'b0;
          out_nxt.event_res       = rwlm_pkg::EV_RELEASED;
        end
      endcase
    end else if (cmd.wake) begin
      out_nxt.who       = head_who_ext[7:0];
      out_nxt.event_res = rwlm_pkg::EV_GRANTED;
      if (wake_rd_r) begin
        rq_pop                  = 1'b1;
        holders_nxt             = holders_r + rwlm_pkg::HOLDERS_ONE;
        out_nxt.exclusive_grant = 1'b0;
        out_nxt.is_last         = rq_single;
      end else begin
        wq_pop                  = 1'b1;
        holders_nxt             = rwlm_pkg::HOLDERS_WRITER;
        out_nxt.exclusive_grant = 1'b1;
        out_nxt.is_last         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holders_r   <= rwlm_pkg::HOLDERS_FREE;
      out_valid_r <= 1'b0;
      wake_rd_r   <= 1'b0;
    end else begin
      holders_r <= holders_nxt;
      wake_rd_r <= wake_rd_nxt;
      if (cmd.eval || cmd.wake) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.wake_pend = wake_pend;
  assign sts.wake_more = wake_rd_r && !rq_single;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

[hw/rtl/rwlm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlm_ctrl
// Sequencer: takes one request, has it evaluated, then steps through the
// waiters it wakes, one grant per pass of the waiter queue read.
// ----------------------------------------------------------------------------
module rwlm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rwlm_pkg::sts_t sts,
  output rwlm_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_READ = 4'b0100,
    ST_WAKE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.out_free) begin
          cmd.eval  = 1'b1;
          state_nxt = sts.wake_pend ? ST_READ : ST_IDLE;
        end
      end
      // The queue head is read into a register; this state lets it settle
      // after the previous pop.
      ST_READ: begin
        state_nxt = ST_WAKE;
      end
      ST_WAKE: begin
        if (sts.out_free) begin
          cmd.wake  = 1'b1;
          state_nxt = sts.wake_more ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

[hw/rtl/reader_writer_lock_manager.sv]
`timescale 1ns / 1ps
// Sequence: a request accepted in IDLE is evaluated in EVAL, and its first result goes into the
// output register; EVAL waits while the result channel stalls.
// Flow: no new request is taken until the last one is through; each woken waiter adds a READ
// and a WAKE state, set by the registered read of the waiter queue head between grants.
// Reset: synchronous, active low; clears the holder count and both queue pointers and fill
// counts at once. Queue entries are not cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
// reader_writer_lock_manager
// Single reader-writer lock with writer preference, holder count, and reader
// and writer waiter queues. Releases wake and grant waiters.
// ----------------------------------------------------------------------------
module reader_writer_lock_manager #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rwlm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rwlm_pkg::out_t out_data
);

  rwlm_pkg::cmd_t cmd;
  rwlm_pkg::sts_t sts;

  rwlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rwlm_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
